[rtl/core/tcp_pkg.sv]
// Shared constants and types for the tile charset packer.
// Used by tcp_scan, tile_charset_packer and tcp_checker; depends on nothing.
package tcp_pkg;

  localparam int SET_ENTRIES = 256;
  localparam int MAX_SETS    = 16;

  localparam int TILE_W  = 64;
  localparam int IDX_W   = (SET_ENTRIES > 1) ? $clog2(SET_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(SET_ENTRIES + 1);
  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int ROW_W   = 6;
  localparam int ROW_MAX = 63;

  localparam logic CMD_LOOKUP     = 1'b0;
  localparam logic CMD_END_OF_ROW = 1'b1;

  // Outcome of one table search, valid for the single cycle that done is high.
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } scan_res_t;

endpackage

[rtl/core/tile_charset_packer.sv]
// Tile charset packer: deduplicates 8x8 one-bit tiles into character sets.
// Depends on tcp_pkg and tcp_scan.
//
// Usage:
//   Present command and tile_bits with start high; the transaction is taken
//   at a rising edge where start is high and busy is low. A lookup
//   (command 0) raises busy for the search and returns one result once
//   the single compare unit, stepping through the entry RAM, has compared
//   the valid entries in index order up to the first match. On a miss with
//   room, the insert is written in the same cycle as the last compare.
//   End of row (command 1) never raises busy; its result follows on the
//   next cycle, so a new transaction may be issued right away.
//   Each result appears for exactly one cycle with done high; the receiver
//   has no way to stall, so it must capture it then. set_number and
//   rows_in_set show the set state after the last completed transaction.
//   Reset (rst, synchronous) empties the current set down to the blank
//   entry, selects set 0 and clears the row counter; no clearing pass over
//   the RAM is needed, since only entries below the fill count are read.
module tile_charset_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        command,
  input  logic [63:0] tile_bits,
  output logic        busy,
  output logic        done,
  output logic [7:0]  char_index,
  output logic        inserted,
  output logic        overflow,
  output logic        retry_row,
  output logic [4:0]  set_number,
  output logic [5:0]  rows_in_set,
  output logic        sets_exhausted
);
  import tcp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } top_state_t;

  top_state_t        state;
  logic [CNT_W-1:0]  working_count;
  logic [CNT_W-1:0]  committed_count;
  logic              row_failed;
  logic [SET_W-1:0]  current_set;
  logic [ROW_W-1:0]  row_count;
  logic              accept;
  logic              scan_go;
  logic              room;
  logic              wr_en;
  scan_res_t         scan_res;

  assign accept  = start && (state == ST_IDLE);
  assign scan_go = accept && (command == CMD_LOOKUP);
  assign room    = (working_count != CNT_W'(SET_ENTRIES));
  assign wr_en   = scan_res.done && !scan_res.hit && room;

  tcp_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .go        (scan_go),
    .tile      (tile_bits),
    .limit     (working_count),
    .wr_en     (wr_en),
    .wr_addr   (working_count[IDX_W-1:0]),
    .res       (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      working_count   <= CNT_W'(1);
      committed_count <= CNT_W'(1);
      row_failed      <= 1'b0;
      current_set     <= '0;
      row_count       <= '0;
      done            <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (scan_go) begin
            state <= ST_SCAN;
          end else if (accept) begin
            done <= 1'b1;
            if (!row_failed) begin
              committed_count <= working_count;
              if (row_count != ROW_W'(ROW_MAX)) begin
                row_count <= row_count + ROW_W'(1);
              end
            end else begin
              row_failed <= 1'b0;
              if (current_set != SET_W'(MAX_SETS - 1)) begin
                current_set     <= current_set + SET_W'(1);
                working_count   <= CNT_W'(1);
                committed_count <= CNT_W'(1);
                row_count       <= '0;
              end else begin
                // Out of sets: drop the row's additions.
                working_count <= committed_count;
              end
            end
          end
        end
        ST_SCAN: begin
          if (scan_res.done) begin
            state <= ST_IDLE;
            done  <= 1'b1;
            if (wr_en) begin
              working_count <= working_count + CNT_W'(1);
            end else if (!scan_res.hit) begin
              row_failed <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload; only meaningful while done is high.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && scan_res.done) begin
      inserted       <= wr_en;
      overflow       <= !scan_res.hit && !room;
      retry_row      <= 1'b0;
      sets_exhausted <= 1'b0;
      if (scan_res.hit) begin
        char_index <= 8'(scan_res.idx);
      end else if (room) begin
        char_index <= 8'(working_count[IDX_W-1:0]);
      end else begin
        char_index <= 8'd0;
      end
    end else if (accept && command == CMD_END_OF_ROW) begin
      char_index     <= 8'd0;
      inserted       <= 1'b0;
      overflow       <= 1'b0;
      retry_row      <= row_failed;
      sets_exhausted <= row_failed && (current_set == SET_W'(MAX_SETS - 1));
    end
  end

  assign busy        = (state == ST_SCAN);
  assign set_number  = 5'(current_set);
  assign rows_in_set = row_count;

endmodule

[rtl/core/tcp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/tcp_scan.sv]
// Sequential table search: one 64-bit compare per cycle against the entry
// store, first match in index order. Depends on tcp_pkg and tcp_ram.
module tcp_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [tcp_pkg::TILE_W-1:0]  tile,
  input  logic [tcp_pkg::CNT_W-1:0]   limit,
  input  logic                        wr_en,
  input  logic [tcp_pkg::IDX_W-1:0]   wr_addr,
  output tcp_pkg::scan_res_t          res
);
  import tcp_pkg::*;

  typedef enum logic [1:0] {
    SC_IDLE = 2'b01,
    SC_RUN  = 2'b10
  } scan_state_t;

  scan_state_t       state;
  logic [IDX_W-1:0]  cmp_idx;
  logic [CNT_W-1:0]  limit_q;
  logic [TILE_W-1:0] tile_q;
  logic [TILE_W-1:0] rd_data;
  logic [TILE_W-1:0] comparand;
  logic [IDX_W-1:0]  rd_addr;
  logic              match;
  logic              last;

  // Read one entry ahead of the compare so the registered read lines up.
  assign rd_addr = cmp_idx + IDX_W'(1);

  tcp_ram #(
    .WIDTH (TILE_W),
    .DEPTH (SET_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (tile_q),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Entry 0 is the blank tile and never lives in the RAM.
  assign comparand = (cmp_idx == '0) ? '0 : rd_data;
  assign match     = (comparand == tile_q);
  assign last      = ((CNT_W'(cmp_idx) + CNT_W'(1)) == limit_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= SC_IDLE;
      cmp_idx <= '0;
    end else begin
      case (state)
        SC_IDLE: begin
          if (go) begin
            state   <= SC_RUN;
            cmp_idx <= '0;
          end
        end
        SC_RUN: begin
          if (match || last) begin
            state <= SC_IDLE;
          end else begin
            cmp_idx <= cmp_idx + IDX_W'(1);
          end
        end
        default: begin
          state <= SC_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (go && state == SC_IDLE) begin
      tile_q  <= tile;
      limit_q <= limit;
    end
  end

  assign res.done  = (state == SC_RUN) && (match || last);
  assign res.hit   = match;
  assign res.idx   = cmp_idx;

endmodule

[rtl/core/tcp_checker.sv]
// Port-level checks for tile_charset_packer, attached by bind.
// Depends on tcp_pkg for command codes.
module tcp_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       command,
  input logic       busy,
  input logic       done,
  input logic [7:0] char_index,
  input logic       inserted,
  input logic       overflow,
  input logic       retry_row,
  input logic       sets_exhausted
);
  import tcp_pkg::*;

  // A lookup transaction always raises busy for the search once it is taken.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == CMD_LOOKUP |=> busy)
    else $error("lookup did not raise busy");

  // End of row answers on the very next cycle without going busy.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == CMD_END_OF_ROW |=> done && !busy)
    else $error("end of row result missing");

  // Result cycles never overlap a running search and flag at most one of inserted, overflow and retry_row.
  assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $onehot0({inserted, overflow, retry_row}))
    else $error("inconsistent result flags");

  // Running out of sets is only reported on a retried row; inserts skip blank.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (!sets_exhausted || retry_row) && (!inserted || char_index != 8'd0))
    else $error("bad exhausted or insert index");

endmodule

bind tile_charset_packer tcp_checker u_tcp_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .command        (command),
  .busy           (busy),
  .done           (done),
  .char_index     (char_index),
  .inserted       (inserted),
  .overflow       (overflow),
  .retry_row      (retry_row),
  .sets_exhausted (sets_exhausted)
);
